[hdl/kts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg
// Shared constants and register codes of the Kalman trajectory stabilizer.
// ----------------------------------------------------------------------------
package kts_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ACC_WIDTH_DEF = 48;
   localparam int DET_LIMIT_DEF = 20;

   localparam int MOTION_W   = 32;
   localparam int DET_W      = 12;
   localparam int NOISE_W    = 32;
   localparam int VAR_W      = 32;
   localparam int PP_W       = 33;
   localparam int DEN_W      = 34;
   localparam int CHUNK_W    = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 32'd262;
   localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 32'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KALMAN_ENABLE      = 2'd0,
      CSR_DETECT_COMP_ENABLE = 2'd1,
      CSR_PROCESS_NOISE      = 2'd2,
      CSR_MEASURE_NOISE      = 2'd3
   } csr_index_type;

endpackage

[hdl/kts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_if
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface kts_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [kts_pkg::MOTION_W-1:0] motion_dx;
   logic signed [kts_pkg::MOTION_W-1:0] motion_dy;
   logic signed [kts_pkg::MOTION_W-1:0] motion_da;
   logic signed [kts_pkg::DET_W-1:0]    det_dx;
   logic signed [kts_pkg::DET_W-1:0]    det_dy;

   modport source (output valid, output motion_dx, output motion_dy, output motion_da,
                   output det_dx, output det_dy, input ready);
   modport sink (input valid, input motion_dx, input motion_dy, input motion_da,
                 input det_dx, input det_dy, output ready);
endinterface

interface kts_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kts_pkg::MOTION_W-1:0] corr_dx;
   logic signed [kts_pkg::MOTION_W-1:0] corr_dy;
   logic signed [kts_pkg::MOTION_W-1:0] corr_da;

   modport source (output valid, output corr_dx, output corr_dy, output corr_da,
                   input ready);
   modport sink (input valid, input corr_dx, input corr_dy, input corr_da,
                 output ready);
endinterface

[hdl/kts_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_div
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kts_div #(
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [kts_pkg::PP_W-1:0]     numer,
   input  logic [kts_pkg::DEN_W-1:0]    denom,
   output logic                         done,
   output logic [FRAC_BITS:0]           quot
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [kts_pkg::DEN_W:0]     rem_ff, rem_in;
   logic [kts_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [FRAC_BITS:0]          quot_ff, quot_in;
   logic                        ge;
   logic [kts_pkg::DEN_W:0]     rem_step;

   assign ge       = rem_ff >= {1'b0, den_ff};
   assign rem_step = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_BITS);
         rem_in  = {2'b00, numer};
         den_in  = denom;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = {rem_step[kts_pkg::DEN_W-1:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-1:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[hdl/kts_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_mul
// Shared 32-bit by gain-width multiplier with registered product.
// ----------------------------------------------------------------------------
module kts_mul #(
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic [kts_pkg::CHUNK_W-1:0]               a,
   input  logic [FRAC_BITS:0]                        b,
   output logic [kts_pkg::CHUNK_W+FRAC_BITS:0]       p
);

   localparam int PW = kts_pkg::CHUNK_W + FRAC_BITS + 1;

   logic [PW-1:0] prod_ff, prod_in;

   assign prod_in = PW'(a) * PW'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign p = prod_ff;

endmodule

[hdl/kalman_trajectory_stabilizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_trajectory_stabilizer_top
// Per-frame motion smoothing with a shared scalar Kalman filter on three axes.
// ----------------------------------------------------------------------------
// One frame is taken at a time; req_bus.ready is high only while the block is
// idle. With the filter running, the work on a frame is done by the gain
// divider, which makes one quotient bit per cycle (FRAC_BITS+1 steps), and by
// the single 32-bit multiplier, which scales the three estimate steps and the
// variance one 32-bit chunk per cycle, over NCH = ceil(max(ACC_WIDTH+1, 33)/32)
// chunks. The first frame after reset, with the filter on, only accumulates the
// trajectory and clears the estimates, and a frame with the filter off goes
// straight to the output stage. A finished result waits in the output register
// while the next frame is taken.
// ----------------------------------------------------------------------------
module kalman_trajectory_stabilizer_top #(
   parameter int FRAC_BITS = kts_pkg::FRAC_BITS_DEF,
   parameter int ACC_WIDTH = kts_pkg::ACC_WIDTH_DEF,
   parameter int DET_LIMIT = kts_pkg::DET_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   kts_req_if.sink                            req_bus,
   kts_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [kts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int MW   = kts_pkg::MOTION_W;
   localparam int DTW  = kts_pkg::DET_W;
   localparam int M_W  = ((DTW + FRAC_BITS > MW) ? DTW + FRAC_BITS : MW) + 1;
   localparam int TW   = ((ACC_WIDTH > M_W) ? ACC_WIDTH : M_W) + 1;
   localparam int DW   = ACC_WIDTH + 1;
   localparam int OPN  = (DW > kts_pkg::PP_W) ? DW : kts_pkg::PP_W;
   localparam int CKW  = kts_pkg::CHUNK_W;
   localparam int NCH  = (OPN + CKW - 1) / CKW;
   localparam int OPW  = NCH * CKW;
   localparam int AW   = OPW + FRAC_BITS + 1;
   localparam int OW   = ((DW > M_W) ? DW : M_W) + 2;
   localparam int CW   = $clog2(NCH + 1);
   localparam int VW   = kts_pkg::VAR_W;
   localparam int NW   = kts_pkg::NOISE_W;
   localparam int AXW  = kts_pkg::AXIS_W;
   localparam int AXES = kts_pkg::AXES;

   localparam logic signed [TW-1:0] ACC_MAX_T = TW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
   localparam logic signed [TW-1:0] ACC_MIN_T = -ACC_MAX_T - 1;
   localparam logic signed [OW-1:0] OUT_MAX   = OW'(2147483647);
   localparam logic signed [OW-1:0] OUT_MIN   = -OUT_MAX - 1;
   localparam logic [FRAC_BITS:0]   ONE_K     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VW-1:0]        VAR_ONE   = VW'(ONE_K);
   localparam logic [AW-1:0]        VAR_CAP   = AW'({VW{1'b1}});
   localparam logic [AXW-1:0]       LAST_AXIS = AXW'(AXES - 1);
   localparam logic [CW-1:0]        LAST_CK   = CW'(NCH);

   typedef enum logic [3:0] {
      S_IDLE, S_TRAJ, S_DIV_GO, S_DIV_WAIT, S_EST_LOAD, S_EST_MUL, S_EST_UPD,
      S_VAR_LOAD, S_VAR_MUL, S_VAR_UPD, S_OUT, S_FIN
   } state_type;

   state_type                    state_ff, state_in;
   logic                         kal_en_ff, kal_en_in;
   logic                         det_en_ff, det_en_in;
   logic [NW-1:0]                q_ff, q_in;
   logic [NW-1:0]                r_ff, r_in;
   logic signed [ACC_WIDTH-1:0]  traj_ff [AXES], traj_in [AXES];
   logic signed [ACC_WIDTH-1:0]  est_ff [AXES], est_in [AXES];
   logic [VW-1:0]                var_ff, var_in;
   logic                         first_ff, first_in;
   logic signed [M_W-1:0]        m_ff [AXES], m_in [AXES];
   logic                         filt_ff, filt_in;
   logic                         skip_ff, skip_in;
   logic [AXW-1:0]               axis_ff, axis_in;
   logic [FRAC_BITS:0]           k_ff, k_in;
   logic [FRAC_BITS:0]           kmul_ff, kmul_in;
   logic [OPW-1:0]               op_ff, op_in;
   logic [AW-1:0]                acc_ff, acc_in;
   logic [CW-1:0]                chunk_ff, chunk_in;
   logic                         neg_ff, neg_in;
   logic [MW-1:0]                res_ff [AXES], res_in [AXES];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]                corr_dx_ff, corr_dx_in;
   logic [MW-1:0]                corr_dy_ff, corr_dy_in;
   logic [MW-1:0]                corr_da_ff, corr_da_in;

   logic [DTW-1:0]               det_x_abs, det_y_abs;
   logic                         det_use;
   logic signed [M_W-1:0]        m_new [AXES];
   logic signed [ACC_WIDTH-1:0]  x_cur, z_cur;
   logic signed [M_W-1:0]        m_cur;
   logic signed [TW-1:0]         tsum;
   logic signed [ACC_WIDTH-1:0]  tsat;
   logic signed [DW-1:0]         dlt;
   logic [DW-1:0]                dmag;
   logic [DW-1:0]                step;
   logic [DW-1:0]                x_next;
   logic [kts_pkg::PP_W-1:0]     pp;
   logic [kts_pkg::DEN_W-1:0]    den;
   logic [AW-1:0]                np;
   logic signed [OW-1:0]         osum;
   logic [MW-1:0]                osat;
   logic                         div_start;
   logic                         div_done;
   logic [FRAC_BITS:0]           div_quot;
   logic [CKW+FRAC_BITS:0]       mul_p;

   kts_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (pp),
      .denom (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   kts_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .a     (op_ff[OPW-1 -: CKW]),
      .b     (kmul_ff),
      .p     (mul_p)
   );

   // detector offset gate and compensated motion
   assign det_x_abs = req_bus.det_dx[DTW-1] ? DTW'(-req_bus.det_dx) : DTW'(req_bus.det_dx);
   assign det_y_abs = req_bus.det_dy[DTW-1] ? DTW'(-req_bus.det_dy) : DTW'(req_bus.det_dy);
   assign det_use   = det_en_ff
                      && (det_x_abs != '0) && (det_x_abs < DTW'(DET_LIMIT))
                      && (det_y_abs != '0) && (det_y_abs < DTW'(DET_LIMIT));

   assign m_new[0] = M_W'(req_bus.motion_dx)
                     + (det_use ? (M_W'(req_bus.det_dx) <<< FRAC_BITS) : M_W'(0));
   assign m_new[1] = M_W'(req_bus.motion_dy)
                     + (det_use ? (M_W'(req_bus.det_dy) <<< FRAC_BITS) : M_W'(0));
   assign m_new[2] = M_W'(req_bus.motion_da);

   // per-axis datapath
   assign x_cur = est_ff[axis_ff];
   assign z_cur = traj_ff[axis_ff];
   assign m_cur = m_ff[axis_ff];

   assign tsum = TW'(z_cur) + TW'(m_cur);

   always_comb begin
      if (tsum > ACC_MAX_T) begin
         tsat = ACC_WIDTH'(ACC_MAX_T);
      end else if (tsum < ACC_MIN_T) begin
         tsat = ACC_WIDTH'(ACC_MIN_T);
      end else begin
         tsat = ACC_WIDTH'(tsum);
      end
   end

   assign dlt    = DW'(z_cur) - DW'(x_cur);
   assign dmag   = dlt[DW-1] ? DW'(-dlt) : DW'(dlt);
   assign step   = DW'(acc_ff >> FRAC_BITS);
   assign x_next = neg_ff ? (DW'(x_cur) - step) : (DW'(x_cur) + step);

   assign pp  = kts_pkg::PP_W'(var_ff) + kts_pkg::PP_W'(q_ff);
   assign den = kts_pkg::DEN_W'(pp) + kts_pkg::DEN_W'(r_ff);
   assign np  = acc_ff >> FRAC_BITS;

   assign osum = OW'(m_cur) + (filt_ff ? (OW'(x_cur) - OW'(z_cur)) : OW'(0));

   always_comb begin
      if (osum > OUT_MAX) begin
         osat = MW'(OUT_MAX);
      end else if (osum < OUT_MIN) begin
         osat = MW'(OUT_MIN);
      end else begin
         osat = MW'(osum);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kal_en_in    = kal_en_ff;
      det_en_in    = det_en_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      traj_in      = traj_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      first_in     = first_ff;
      m_in         = m_ff;
      filt_in      = filt_ff;
      skip_in      = skip_ff;
      axis_in      = axis_ff;
      k_in         = k_ff;
      kmul_in      = kmul_ff;
      op_in        = op_ff;
      acc_in       = acc_ff;
      chunk_in     = chunk_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      corr_dx_in   = corr_dx_ff;
      corr_dy_in   = corr_dy_ff;
      corr_da_in   = corr_da_ff;
      div_start    = 1'b0;

      if (csr_we) begin
         case (kts_pkg::csr_index_type'(csr_index))
            kts_pkg::CSR_KALMAN_ENABLE:      kal_en_in = csr_wdata[0];
            kts_pkg::CSR_DETECT_COMP_ENABLE: det_en_in = csr_wdata[0];
            kts_pkg::CSR_PROCESS_NOISE:      q_in      = NW'(csr_wdata);
            kts_pkg::CSR_MEASURE_NOISE:      r_in      = NW'(csr_wdata);
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               m_in     = m_new;
               filt_in  = kal_en_ff;
               skip_in  = first_ff;
               first_in = 1'b0;
               axis_in  = '0;
               state_in = kal_en_ff ? S_TRAJ : S_OUT;
            end
         end
         S_TRAJ: begin
            traj_in[axis_ff] = tsat;
            if (axis_ff == LAST_AXIS) begin
               axis_in = '0;
               if (skip_ff) begin
                  for (int i = 0; i < AXES; i++) begin
                     est_in[i] = '0;
                  end
                  var_in   = VAR_ONE;
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV_GO;
               end
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               k_in     = (den == '0) ? '0 : div_quot;
               axis_in  = '0;
               state_in = S_EST_LOAD;
            end
         end
         S_EST_LOAD: begin
            op_in    = OPW'(dmag);
            neg_in   = dlt[DW-1];
            kmul_in  = k_ff;
            acc_in   = '0;
            chunk_in = '0;
            state_in = S_EST_MUL;
         end
         S_EST_MUL, S_VAR_MUL: begin
            op_in = op_ff << CKW;
            if (chunk_ff != '0) begin
               acc_in = (acc_ff << CKW) + AW'(mul_p);
            end
            if (chunk_ff == LAST_CK) begin
               state_in = (state_ff == S_EST_MUL) ? S_EST_UPD : S_VAR_UPD;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_EST_UPD: begin
            est_in[axis_ff] = ACC_WIDTH'(x_next);
            if (axis_ff == LAST_AXIS) begin
               state_in = S_VAR_LOAD;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_EST_LOAD;
            end
         end
         S_VAR_LOAD: begin
            op_in    = OPW'(pp);
            kmul_in  = ONE_K - k_ff;
            acc_in   = '0;
            chunk_in = '0;
            state_in = S_VAR_MUL;
         end
         S_VAR_UPD: begin
            var_in   = (np > VAR_CAP) ? {VW{1'b1}} : VW'(np);
            axis_in  = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            res_in[axis_ff] = osat;
            if (axis_ff == LAST_AXIS) begin
               state_in = S_FIN;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               corr_dx_in   = res_ff[0];
               corr_dy_in   = res_ff[1];
               corr_da_in   = res_ff[2];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kal_en_ff    <= 1'b1;
         det_en_ff    <= 1'b0;
         q_ff         <= kts_pkg::PROCESS_NOISE_RST;
         r_ff         <= kts_pkg::MEASURE_NOISE_RST;
         for (int i = 0; i < AXES; i++) begin
            traj_ff[i] <= '0;
            est_ff[i]  <= '0;
         end
         var_ff       <= VAR_ONE;
         first_ff     <= 1'b1;
         axis_ff      <= '0;
         chunk_ff     <= '0;
         filt_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kal_en_ff    <= kal_en_in;
         det_en_ff    <= det_en_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         traj_ff      <= traj_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         first_ff     <= first_in;
         m_ff         <= m_in;
         filt_ff      <= filt_in;
         skip_ff      <= skip_in;
         axis_ff      <= axis_in;
         k_ff         <= k_in;
         kmul_ff      <= kmul_in;
         op_ff        <= op_in;
         acc_ff       <= acc_in;
         chunk_ff     <= chunk_in;
         neg_ff       <= neg_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
         corr_dx_ff   <= corr_dx_in;
         corr_dy_ff   <= corr_dy_in;
         corr_da_ff   <= corr_da_in;
      end
   end

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.corr_dx = corr_dx_ff;
   assign rsp_bus.corr_dy = corr_dy_ff;
   assign rsp_bus.corr_da = corr_da_ff;

endmodule

[bench/kalman_trajectory_stabilizer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_trajectory_stabilizer_top_tb
// Self-checking bench for the frame stabilizer. Frames are offered on the
// request channel and corrected motion is collected on the response channel.
// Both sides idle and stall at random, and a long response hold-off backs up
// the block. A local copy of the trajectory filter predicts every result.
// Results are compared field by field, in order, under several register
// settings: filter on and off, detector offsets on and off, and noise
// variances at zero, at full scale and in between.
// ----------------------------------------------------------------------------
module kalman_trajectory_stabilizer_top_tb;

   localparam int        FB            = kts_pkg::FRAC_BITS_DEF;
   localparam int        ACC           = kts_pkg::ACC_WIDTH_DEF;
   localparam int        DETL          = kts_pkg::DET_LIMIT_DEF;
   localparam longint    ACC_MAX       = (longint'(1) <<< (ACC - 1)) - 1;
   localparam longint    ACC_MIN       = -ACC_MAX - 1;
   localparam bit [63:0] GAIN_ONE      = 64'd1 << FB;
   localparam int        CYCLE_LIMIT   = 400000;
   localparam int        HOLD_CYCLES   = 300;
   localparam int        DRAIN_PAD     = 60;
   localparam int        RANDOM_PHASES = 10;
   localparam int        PHASE_FRAMES  = 70;
   localparam int        MAX_WAIT      = 12;
   localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN     = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] da;
      logic [11:0] ddx;
      logic [11:0] ddy;
   } frame_type;

   typedef struct packed {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] ca;
   } corr_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [kts_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [kts_pkg::CSR_DATA_W-1:0] csr_wdata;

   kts_req_if req_ch();
   kts_rsp_if rsp_ch();

   kalman_trajectory_stabilizer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter state and register copy
   bit          filter_on;
   bit          det_comp_on;
   bit [31:0]   q_noise;
   bit [31:0]   r_noise;
   longint      traj_sum[3];
   longint      smooth_est[3];
   bit [31:0]   err_var;
   bit          fresh_start;

   frame_type   frames_to_send[$];
   corr_type    expected_corr[$];

   int          failures = 0;
   int          cycle_count = 0;
   bit          no_idle = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          gap_left = 0;
   bit          req_done = 0;
   bit          rsp_done = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit det_in_window(logic [11:0] d);
      int mag;
      mag = int'($signed(d));
      if (mag < 0) mag = -mag;
      return (mag > 0) && (mag < DETL);
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return S32_MAX;
      if (v < -64'sd2147483648) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   function automatic corr_type stabilize_frame(frame_type f);
      longint     m[3];
      longint     x;
      longint     z;
      bit [63:0]  pp;
      bit [63:0]  den;
      bit [63:0]  gain;
      bit [63:0]  np;
      bit [63:0]  mag;
      bit [127:0] prod;
      corr_type   c;
      int         k;
      m[0] = longint'($signed(f.dx));
      m[1] = longint'($signed(f.dy));
      m[2] = longint'($signed(f.da));
      if (det_comp_on && det_in_window(f.ddx) && det_in_window(f.ddy)) begin
         m[0] = m[0] + (longint'($signed(f.ddx)) <<< FB);
         m[1] = m[1] + (longint'($signed(f.ddy)) <<< FB);
      end
      if (filter_on) begin
         for (k = 0; k < 3; k++) traj_sum[k] = clamp_acc(traj_sum[k] + m[k]);
         if (fresh_start) begin
            for (k = 0; k < 3; k++) smooth_est[k] = 0;
            err_var = 32'd1 << FB;
         end else begin
            pp   = 64'(err_var) + 64'(q_noise);
            den  = pp + 64'(r_noise);
            gain = (den != 64'd0) ? (pp << FB) / den : 64'd0;
            if (gain > GAIN_ONE) gain = GAIN_ONE;
            for (k = 0; k < 3; k++) begin
               x = smooth_est[k];
               z = traj_sum[k];
               if (z >= x) begin
                  mag  = z - x;
                  prod = 128'(mag) * 128'(gain);
                  smooth_est[k] = x + longint'(prod >> FB);
               end else begin
                  mag  = x - z;
                  prod = 128'(mag) * 128'(gain);
                  smooth_est[k] = x - longint'(prod >> FB);
               end
            end
            np = ((GAIN_ONE - gain) * pp) >> FB;
            err_var = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
         end
         for (k = 0; k < 3; k++) m[k] = m[k] + (smooth_est[k] - traj_sum[k]);
      end
      fresh_start = 1'b0;
      c.cx = clamp32(m[0]);
      c.cy = clamp32(m[1]);
      c.ca = clamp32(m[2]);
      return c;
   endfunction

   function automatic logic [31:0] rand_motion();
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         2: return $urandom;
         3: begin
            case ($urandom_range(0, 4))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 32'd0;
               3: return 32'hFFFF_FFFF;
               default: return 32'd1;
            endcase
         end
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [11:0] rand_det();
      if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, 48)) - 12'd24;
      return 12'($urandom);
   endfunction

   function automatic logic [31:0] pick_noise();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return kts_pkg::PROCESS_NOISE_RST;
         3: return kts_pkg::MEASURE_NOISE_RST;
         4: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic queue_frame(logic [31:0] dx, logic [31:0] dy, logic [31:0] da,
                              logic [11:0] ddx, logic [11:0] ddy);
      frame_type f;
      f = '{dx, dy, da, ddx, ddy};
      frames_to_send.insert(frames_to_send.size(), f);
   endtask

   task automatic csr_write(kts_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         kts_pkg::CSR_KALMAN_ENABLE:      filter_on   = data[0];
         kts_pkg::CSR_DETECT_COMP_ENABLE: det_comp_on = data[0];
         kts_pkg::CSR_PROCESS_NOISE:      q_noise     = data;
         kts_pkg::CSR_MEASURE_NOISE:      r_noise     = data;
         default: ;
      endcase
   endtask

   task automatic set_config(bit kal, bit det, logic [31:0] q, logic [31:0] r);
      csr_write(kts_pkg::CSR_KALMAN_ENABLE, {31'd0, kal});
      csr_write(kts_pkg::CSR_DETECT_COMP_ENABLE, {31'd0, det});
      csr_write(kts_pkg::CSR_PROCESS_NOISE, q);
      csr_write(kts_pkg::CSR_MEASURE_NOISE, r);
   endtask

   // wait until every queued frame is sent and every result is back
   task automatic settle();
      while (frames_to_send.size() != 0 || req_ch.valid || expected_corr.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      frame_type f;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_done) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (frames_to_send.size() != 0) begin
            f = frames_to_send.pop_front();
            req_ch.motion_dx <= f.dx;
            req_ch.motion_dy <= f.dy;
            req_ch.motion_da <= f.da;
            req_ch.det_dx    <= f.ddx;
            req_ch.det_dy    <= f.ddy;
            req_ch.valid     <= 1'b1;
            gap_left = rand_wait();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready with per-result stalls and the long hold-off
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_done) begin
         stall_left = rand_wait();
         rsp_ch.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= (stall_left == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // request monitor: predict on every transfer
   always @(posedge clock) begin
      req_done <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         expected_corr.insert(expected_corr.size(),
                              stabilize_frame({req_ch.motion_dx, req_ch.motion_dy,
                                               req_ch.motion_da, req_ch.det_dx,
                                               req_ch.det_dy}));
   end

   // response monitor
   always @(posedge clock) begin
      corr_type want;
      rsp_done <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_corr.size() == 0) begin
            failures++;
            $error("result with no frame pending: corr_dx %0d corr_dy %0d corr_da %0d",
                   $signed(rsp_ch.corr_dx), $signed(rsp_ch.corr_dy),
                   $signed(rsp_ch.corr_da));
         end else begin
            want = expected_corr.pop_front();
            if (rsp_ch.corr_dx !== want.cx) begin
               failures++;
               $error("corr_dx: expected %0d, actual %0d", $signed(want.cx),
                      $signed(rsp_ch.corr_dx));
            end
            if (rsp_ch.corr_dy !== want.cy) begin
               failures++;
               $error("corr_dy: expected %0d, actual %0d", $signed(want.cy),
                      $signed(rsp_ch.corr_dy));
            end
            if (rsp_ch.corr_da !== want.ca) begin
               failures++;
               $error("corr_da: expected %0d, actual %0d", $signed(want.ca),
                      $signed(rsp_ch.corr_da));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("kalman_trajectory_stabilizer_top_tb: FAIL");
      $finish;
   end

   initial begin
      int p;
      int n;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = kts_pkg::CSR_KALMAN_ENABLE;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.motion_dx = '0;
      req_ch.motion_dy = '0;
      req_ch.motion_da = '0;
      req_ch.det_dx    = '0;
      req_ch.det_dy    = '0;
      rsp_ch.ready     = 1'b0;
      filter_on        = 1'b1;
      det_comp_on      = 1'b0;
      q_noise          = kts_pkg::PROCESS_NOISE_RST;
      r_noise          = kts_pkg::MEASURE_NOISE_RST;
      for (n = 0; n < 3; n++) begin
         traj_sum[n]   = 0;
         smooth_est[n] = 0;
      end
      err_var     = 32'd1 << FB;
      fresh_start = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, first frame, detector offsets ignored
      queue_frame(32'sd98304, -32'sd131072, 32'sd655, 12'sd5, 12'sd5);
      queue_frame(S32_MAX, S32_MIN, S32_MAX, 12'd0, 12'd0);
      queue_frame(S32_MIN, S32_MAX, S32_MIN, -12'sd1, 12'sd1);
      queue_frame(32'd0, 32'd0, 32'd0, 12'sd19, -12'sd19);
      queue_frame(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 12'h7FF, 12'h800);
      settle();

      // detector window edges
      set_config(1'b1, 1'b1, kts_pkg::PROCESS_NOISE_RST, kts_pkg::MEASURE_NOISE_RST);
      queue_frame(32'sd65536, 32'sd65536, 32'sd0, 12'sd1, 12'sd1);
      queue_frame(-32'sd65536, 32'sd1000, 32'sd10, -12'sd1, -12'sd1);
      queue_frame(32'sd20000, -32'sd20000, 32'sd5, 12'sd19, -12'sd19);
      queue_frame(32'sd20000, 32'sd20000, 32'sd5, 12'sd20, 12'sd5);
      queue_frame(32'sd20000, 32'sd20000, 32'sd5, 12'sd5, -12'sd20);
      queue_frame(32'sd300, 32'sd300, 32'sd3, 12'sd0, 12'sd7);
      queue_frame(32'sd300, 32'sd300, 32'sd3, 12'sd7, 12'sd0);
      queue_frame(32'sd300, 32'sd300, 32'sd3, 12'h7FF, 12'h800);
      queue_frame(S32_MAX, S32_MIN, 32'sd0, 12'sd19, -12'sd19);
      settle();

      // filter off: compensated pass-through
      set_config(1'b0, 1'b1, kts_pkg::PROCESS_NOISE_RST, kts_pkg::MEASURE_NOISE_RST);
      queue_frame(S32_MAX, S32_MIN, 32'sd5, 12'sd19, 12'sd19);
      queue_frame(32'sd123, -32'sd456, 32'sd789, 12'sd3, -12'sd3);
      queue_frame(32'd0, 32'd0, 32'd0, 12'sd25, 12'sd1);
      settle();

      // zero noise: full gain, then a zero denominator holds the estimate
      set_config(1'b1, 1'b0, 32'd0, 32'd0);
      queue_frame(32'sd70000, -32'sd50000, 32'sd900, 12'd0, 12'd0);
      queue_frame(32'sd40000, 32'sd80000, -32'sd900, 12'd0, 12'd0);
      queue_frame(-32'sd10000, 32'sd5000, 32'sd100, 12'd0, 12'd0);
      settle();

      // full scale noise: a gain near one half, and the output saturates
      set_config(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_frame(S32_MAX, S32_MIN, S32_MAX, 12'd0, 12'd0);
      queue_frame(S32_MAX, S32_MIN, S32_MAX, 12'd0, 12'd0);
      settle();
      set_config(1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);
      queue_frame(S32_MAX, S32_MIN, S32_MAX, 12'd0, 12'd0);
      queue_frame(S32_MIN, S32_MAX, S32_MIN, 12'd0, 12'd0);
      settle();
      set_config(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0);
      queue_frame(32'sd1234567, -32'sd7654321, 32'sd42, 12'sd9, -12'sd9);
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_config($urandom_range(0, 4) != 0, $urandom_range(0, 1), pick_noise(),
                    pick_noise());
         no_idle = (p % 4 == 2);
         for (n = 0; n < PHASE_FRAMES; n++)
            queue_frame(rand_motion(), rand_motion(), rand_motion(), rand_det(), rand_det());
         if (p == 3) begin
            @(posedge clock);
            hold_requests++;
         end
         settle();
      end

      if (failures == 0) begin
         $display("kalman_trajectory_stabilizer_top_tb: PASS");
      end else begin
         $display("kalman_trajectory_stabilizer_top_tb: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/kts_pkg.sv
hdl/kts_if.sv
hdl/kts_div.sv
hdl/kts_mul.sv
hdl/kalman_trajectory_stabilizer_top.sv
bench/kalman_trajectory_stabilizer_top_tb.sv
